// ----- hw/rtl/thermocouple_channel_processor_defines.svh -----
// ----------------------------------------------------------------------------
// thermocouple channel processor assertion macros
// shared assertion helpers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef THERMOCOUPLE_CHANNEL_PROCESSOR_DEFINES_SVH
`define THERMOCOUPLE_CHANNEL_PROCESSOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define TCP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TCP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TCP_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- hw/rtl/tcp_pkg.sv -----
// ----------------------------------------------------------------------------
// tcp_pkg
// shared types, constants and float helpers of the thermocouple processor
// ----------------------------------------------------------------------------
`default_nettype none
package tcp_pkg;
  localparam int unsigned TableDepth = 42;
  localparam int unsigned LimitBase  = 32;
  localparam int unsigned AddrW      = 6;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_START  = 2'd2;
  localparam logic [1:0] ACT_RSVD   = 2'd3;

  localparam logic [1:0] RANGE_GND  = 2'd0;
  localparam logic [1:0] RANGE_TEMP = 2'd1;
  localparam logic [1:0] RANGE_MV   = 2'd2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_REF  = 2'd1;
  localparam logic [1:0] KIND_TC   = 2'd2;

  localparam logic [1:0] MODE_MEAS = 2'd0;
  localparam logic [1:0] MODE_ZERO = 2'd1;
  localparam logic [1:0] MODE_HALF = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  localparam logic [31:0] F_ZERO    = 32'h0000_0000;
  localparam logic [31:0] F_ONE     = 32'h3f80_0000;
  localparam logic [31:0] F_HALF    = 32'h3f00_0000;
  localparam logic [31:0] F_HUNDRED = 32'h42c8_0000;
  localparam logic [31:0] F_W_TC    = 32'h3dcc_cccd;  // 0.1f
  localparam logic [31:0] F_W_AUX   = 32'h3e4c_cccd;  // 0.2f
  localparam logic [31:0] F_MV_SCL  = 32'h4205_5555;  // 100/3 f

  localparam logic [3:0] SeedStart = 4'd8;

  // shared float unit operations
  typedef enum logic [1:0] {
    FOP_ADD = 2'd0,
    FOP_SUB = 2'd1,
    FOP_MUL = 2'd2,
    FOP_LT  = 2'd3
  } fop_e;

  typedef struct packed {
    fop_e        op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  // a < b, ieee ordered; false on nan
  function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
    logic an, bn, az;
    an = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    bn = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    az = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    if (an || bn || az) return 1'b0;
    if (a[31] != b[31]) return a[31];
    if (!a[31]) return a[30:0] < b[30:0];
    return a[30:0] > b[30:0];
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/tcp_stream_if.sv -----
// ----------------------------------------------------------------------------
// tcp_stream_if
// valid/ready channels of the thermocouple processor
// ----------------------------------------------------------------------------
`default_nettype none
interface tcp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] sample;
  logic [5:0]  table_address;
  logic [31:0] table_word;
  modport source (output valid, action, sample, table_address, table_word, input ready);
  modport sink (input valid, action, sample, table_address, table_word, output ready);
endinterface

interface tcp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  range_select;
  logic [1:0]  value_kind;
  logic [31:0] value;
  modport source (output valid, range_select, value_kind, value, input ready);
  modport sink (input valid, range_select, value_kind, value, output ready);
endinterface

interface tcp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/tcp_fpu.sv -----
// ----------------------------------------------------------------------------
// tcp_fpu
// two-stage single precision add/sub/multiply/compare, round to nearest even
// ----------------------------------------------------------------------------
`default_nettype none
module tcp_fpu (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  tcp_pkg::fpu_req_t    req_i,
  output logic                 done_o,
  output logic [31:0]          res_o
);
  // stage 1: unpack, align or multiply; stage 2: normalize and round
  typedef struct packed {
    logic        special;
    logic [31:0] spec_val;
    logic        sign;
    logic signed [10:0] exp;   // biased exponent of bit 49 of mant
    logic [49:0] mant;         // magnitude, sticky in bit 0
  } mid_t;

  mid_t mid_d, mid_q;
  logic v1_q, v2_q;
  logic [31:0] res_q, res_d;

  always_comb begin
    logic [31:0] a, b;
    logic ea0, eb0, an, bn, ai, bi, sb;
    logic [7:0] ea, eb;
    logic [23:0] ma, mb;
    logic signed [10:0] xa, xb;
    logic [49:0] wa, wb, sh;
    logic [10:0] d;
    logic [47:0] pr;
    a = req_i.a;
    b = req_i.b;
    sb = (req_i.op == tcp_pkg::FOP_SUB) ? ~b[31] : b[31];
    ea = a[30:23]; eb = b[30:23];
    ea0 = (ea == 8'd0); eb0 = (eb == 8'd0);
    ma = {~ea0, a[22:0]}; mb = {~eb0, b[22:0]};
    xa = ea0 ? 11'sd1 : $signed({3'd0, ea});
    xb = eb0 ? 11'sd1 : $signed({3'd0, eb});
    an = (ea == 8'hff) && (a[22:0] != 0);
    bn = (eb == 8'hff) && (b[22:0] != 0);
    ai = (ea == 8'hff) && (a[22:0] == 0);
    bi = (eb == 8'hff) && (b[22:0] == 0);
    mid_d = '0;
    wa = '0; wb = '0; sh = '0; d = '0; pr = '0;
    if (req_i.op == tcp_pkg::FOP_LT) begin
      mid_d.special  = 1'b1;
      mid_d.spec_val = {31'd0, tcp_pkg::f_lt(a, b)};
    end else if (req_i.op == tcp_pkg::FOP_MUL) begin
      mid_d.sign = a[31] ^ b[31];
      // a nan operand passes through quieted, first operand first
      if (an) begin
        mid_d.special = 1'b1; mid_d.spec_val = a | 32'h0040_0000;
      end else if (bn) begin
        mid_d.special = 1'b1; mid_d.spec_val = b | 32'h0040_0000;
      end else if ((ai && b[30:0] == 0) || (bi && a[30:0] == 0)) begin
        mid_d.special = 1'b1; mid_d.spec_val = 32'hffc0_0000;
      end else if (ai || bi) begin
        mid_d.special = 1'b1; mid_d.spec_val = {mid_d.sign, 31'h7f80_0000};
      end else begin
        pr = ma * mb;
        mid_d.mant = {pr, 2'b00};
        // value = pr * 2^(xa+xb-254-46); bit49 weight 2^(xa+xb-127-127+1)
        mid_d.exp = xa + xb - 11'sd126;
      end
    end else begin
      if (an) begin
        mid_d.special = 1'b1; mid_d.spec_val = a | 32'h0040_0000;
      end else if (bn) begin
        mid_d.special = 1'b1; mid_d.spec_val = b | 32'h0040_0000;
      end else if (ai && bi && (a[31] != sb)) begin
        mid_d.special = 1'b1; mid_d.spec_val = 32'hffc0_0000;
      end else if (ai) begin
        mid_d.special = 1'b1; mid_d.spec_val = a;
      end else if (bi) begin
        mid_d.special = 1'b1; mid_d.spec_val = {sb, 31'h7f80_0000};
      end else begin
        // big operand first; bit 49 weight 2^(x-127+1), mantissa msb at 48
        if ({xa, ma} >= {xb, mb}) begin
          wa = {1'b0, ma, 25'd0}; wb = {1'b0, mb, 25'd0};
          d = 11'(xa - xb); mid_d.exp = xa; mid_d.sign = a[31];
        end else begin
          wa = {1'b0, mb, 25'd0}; wb = {1'b0, ma, 25'd0};
          d = 11'(xb - xa); mid_d.exp = xb; mid_d.sign = sb;
        end
        if (d > 11'd49) sh = {49'd0, |wb};
        else sh = (wb >> d) | {49'd0, |(wb & ~({50{1'b1}} << d))};
        if (a[31] == sb) mid_d.mant = wa + sh;
        else mid_d.mant = wa - sh;
        mid_d.exp = mid_d.exp + 11'sd1;
        if (mid_d.mant == 0) begin
          mid_d.special = 1'b1;
          mid_d.spec_val = {(a[31] & sb), 31'd0};
        end
      end
    end
  end

  always_comb begin
    logic [5:0] lz;
    logic [49:0] m;
    logic signed [11:0] e;
    logic [23:0] k;
    logic g, st, up;
    logic [24:0] r;
    lz = 6'd50;
    for (int i = 0; i < 50; i++) begin
      if (mid_q.mant[i]) lz = 6'(49 - i);
    end
    m = mid_q.mant << lz;
    // biased exponent of the leading one after normalization
    e = 12'(mid_q.exp) - $signed({6'd0, lz});
    if (e < 12'sd1) begin
      // subnormal: shift right by 1-e
      if ((12'sd1 - e) > 12'sd49) m = {49'd0, |m};
      else m = (m >> (12'sd1 - e)) | {49'd0, |(m & ~({50{1'b1}} << (12'sd1 - e)))};
      e = 12'sd0;
    end
    k  = m[49:26];
    g  = m[25];
    st = |m[24:0];
    up = g && (st || k[0]);
    r  = {1'b0, k} + {24'd0, up};
    if (r[24]) begin
      r = r >> 1; e = e + 12'sd1;
    end else if (e == 12'sd0 && r[23]) begin
      e = 12'sd1;
    end
    if (mid_q.special) res_d = mid_q.spec_val;
    else if (mid_q.mant == 50'd0) res_d = {mid_q.sign, 31'd0};
    else if (e >= 12'sd255) res_d = {mid_q.sign, 8'hff, 23'd0};
    else res_d = {mid_q.sign, e[7:0], r[22:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_q <= mid_d;
    res_q <= res_d;
  end

  assign done_o = v2_q;
  assign res_o  = res_q;
endmodule
`default_nettype wire

// ----- hw/rtl/tcp_seq.sv -----
// ----------------------------------------------------------------------------
// tcp_seq
// sequencer: averages, segment search and cubic evaluation on the shared fpu
// ----------------------------------------------------------------------------
`default_nettype none
module tcp_seq (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        go_i,
  input  wire logic [1:0]  action_i,
  input  wire logic [31:0] sample_i,
  input  wire logic [5:0]  addr_i,
  input  wire logic [31:0] word_i,
  input  wire logic [1:0]  ref_mode_i,
  output logic             done_o,
  output logic [1:0]       range_o,
  output logic [1:0]       kind_o,
  output logic [31:0]      value_o
);
  typedef enum logic [4:0] {
    S_IDLE, S_SEED, S_SUB, S_WMUL, S_ADD, S_REFSEL, S_T100,
    S_MVMUL, S_MVADD, S_LRD, S_LCMP, S_LNEXT, S_CRD, S_CMUL, S_CACC,
    S_CPW, S_EVDONE, S_DONE
  } state_e;

  state_e      state_q;
  logic        busy_q;        // fpu op in flight
  logic [31:0] tab_q [tcp_pkg::TableDepth];
  logic [31:0] rd_q;
  logic [5:0]  rd_addr;
  logic [31:0] meas_q, gnd_q, refa_q, reft_q, cjmv_q;
  logic [2:0]  slot_q;
  logic [3:0]  seed_q;
  logic [1:0]  range_q, kind_q;
  logic [31:0] val_q, s_q, tmp_q, x_q, acc_q, pw_q, v_q;
  logic        dir_q;
  logic [2:0]  li_q;           // limit index 0..4
  logic [1:0]  seg_q, pi_q;
  logic        start_fpu, fdone;
  tcp_pkg::fpu_req_t req;
  logic [31:0] fres;

  tcp_fpu u_fpu (
    .clk_i, .rst_ni, .start_i(start_fpu), .req_i(req), .done_o(fdone), .res_o(fres)
  );

  // table address for the read
  always_comb begin
    logic [5:0] lb;
    lb = dir_q ? 6'(tcp_pkg::LimitBase + 5) : 6'(tcp_pkg::LimitBase);
    if (state_q == S_CRD) rd_addr = {1'b0, dir_q, seg_q, pi_q};
    else rd_addr = lb + {3'd0, li_q};
  end

  always_ff @(posedge clk_i) begin
    if (go_i && action_i == tcp_pkg::ACT_LOAD && addr_i < 6'(tcp_pkg::TableDepth)) begin
      tab_q[addr_i] <= word_i;
    end
    rd_q <= tab_q[rd_addr];
  end

  // current average operand and weight by slot
  logic [31:0] avg_cur, wgt_cur;
  always_comb begin
    if (slot_q == 3'd1) avg_cur = gnd_q;
    else if (slot_q == 3'd5) avg_cur = refa_q;
    else avg_cur = meas_q;
    wgt_cur = (slot_q == 3'd1 || slot_q == 3'd5) ? tcp_pkg::F_W_AUX : tcp_pkg::F_W_TC;
  end

  always_comb begin
    req = '{op: tcp_pkg::FOP_ADD, a: '0, b: '0};
    start_fpu = 1'b0;
    case (state_q)
      S_SUB:   req = '{op: tcp_pkg::FOP_SUB, a: s_q, b: avg_cur};
      S_WMUL:  req = '{op: tcp_pkg::FOP_MUL, a: wgt_cur, b: tmp_q};
      S_ADD:   req = '{op: tcp_pkg::FOP_ADD, a: avg_cur, b: tmp_q};
      S_T100:  req = '{op: tcp_pkg::FOP_MUL, a: reft_q, b: tcp_pkg::F_HUNDRED};
      S_MVMUL: req = '{op: tcp_pkg::FOP_MUL, a: meas_q, b: tcp_pkg::F_MV_SCL};
      S_MVADD: req = '{op: tcp_pkg::FOP_ADD, a: tmp_q, b: cjmv_q};
      S_LCMP:  req = '{op: tcp_pkg::FOP_LT, a: v_q, b: rd_q};
      S_CMUL:  req = '{op: tcp_pkg::FOP_MUL, a: pw_q, b: rd_q};
      S_CACC:  req = '{op: tcp_pkg::FOP_ADD, a: acc_q, b: tmp_q};
      S_CPW:   req = '{op: tcp_pkg::FOP_MUL, a: pw_q, b: x_q};
      default: req = '{op: tcp_pkg::FOP_ADD, a: '0, b: '0};
    endcase
    case (state_q)
      S_SUB, S_WMUL, S_ADD, S_T100, S_MVMUL, S_MVADD, S_LCMP, S_CMUL, S_CACC, S_CPW:
        start_fpu = !busy_q;
      default: start_fpu = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      meas_q <= '0; gnd_q <= '0; refa_q <= '0; reft_q <= '0; cjmv_q <= '0;
      slot_q <= '0; seed_q <= '0; range_q <= tcp_pkg::RANGE_GND;
      kind_q <= tcp_pkg::KIND_NONE; val_q <= '0;
      dir_q <= 1'b0; li_q <= '0; seg_q <= '0; pi_q <= '0;
      s_q <= '0; tmp_q <= '0; x_q <= '0; acc_q <= '0; pw_q <= '0; v_q <= '0;
    end else begin
      if (start_fpu) busy_q <= 1'b1;
      else if (fdone) busy_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (go_i) begin
            kind_q <= tcp_pkg::KIND_NONE;
            val_q  <= '0;
            s_q    <= sample_i;
            case (action_i)
              tcp_pkg::ACT_SAMPLE: begin
                if (slot_q == 3'd0) range_q <= tcp_pkg::RANGE_GND;
                else if (slot_q == 3'd4) range_q <= tcp_pkg::RANGE_TEMP;
                else range_q <= tcp_pkg::RANGE_MV;
                state_q <= S_SEED;
              end
              tcp_pkg::ACT_START: begin
                range_q <= tcp_pkg::RANGE_GND;
                slot_q  <= '0;
                seed_q  <= tcp_pkg::SeedStart;
                state_q <= S_DONE;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_SEED: begin
          if (seed_q != 4'd0) begin
            if (slot_q == 3'd1) gnd_q <= s_q;
            else if (slot_q == 3'd2) meas_q <= s_q;
            else if (slot_q == 3'd5) refa_q <= s_q;
            seed_q <= seed_q - 4'd1;
          end
          state_q <= S_SUB;
        end
        S_SUB:  if (fdone) begin tmp_q <= fres; state_q <= S_WMUL; end
        S_WMUL: if (fdone) begin tmp_q <= fres; state_q <= S_ADD; end
        S_ADD: begin
          if (fdone) begin
            if (slot_q == 3'd1) begin
              gnd_q <= fres; state_q <= S_EVDONE;
            end else if (slot_q == 3'd5) begin
              refa_q <= fres; state_q <= S_REFSEL;
            end else begin
              meas_q <= fres; state_q <= S_EVDONE;
            end
          end
        end
        S_REFSEL: begin
          case (ref_mode_i)
            tcp_pkg::MODE_MEAS: reft_q <= refa_q;
            tcp_pkg::MODE_ZERO: reft_q <= tcp_pkg::F_ZERO;
            tcp_pkg::MODE_HALF: reft_q <= tcp_pkg::F_HALF;
            default: reft_q <= reft_q;
          endcase
          state_q <= S_T100;
        end
        S_T100: if (fdone) begin
          v_q <= fres; dir_q <= 1'b1; li_q <= '0; state_q <= S_LRD;
        end
        S_MVMUL: if (fdone) begin tmp_q <= fres; state_q <= S_MVADD; end
        S_MVADD: if (fdone) begin
          v_q <= fres; dir_q <= 1'b0; li_q <= '0; state_q <= S_LRD;
        end
        S_LRD: state_q <= S_LCMP;
        S_LCMP: begin
          if (fdone) begin
            if (fres[0]) begin
              if (li_q == 3'd0) begin
                seg_q <= 2'd0; x_q <= rd_q;
              end else begin
                seg_q <= 2'(li_q - 3'd1); x_q <= v_q;
              end
              pi_q <= '0; acc_q <= tcp_pkg::F_ZERO; pw_q <= tcp_pkg::F_ONE;
              state_q <= S_CRD;
            end else if (li_q == 3'd4) begin
              seg_q <= 2'd3; x_q <= rd_q;
              pi_q <= '0; acc_q <= tcp_pkg::F_ZERO; pw_q <= tcp_pkg::F_ONE;
              state_q <= S_CRD;
            end else begin
              li_q <= li_q + 3'd1; state_q <= S_LRD;
            end
          end
        end
        S_CRD:  state_q <= S_CMUL;
        S_CMUL: if (fdone) begin tmp_q <= fres; state_q <= S_CACC; end
        S_CACC: if (fdone) begin acc_q <= fres; state_q <= S_CPW; end
        S_CPW: begin
          if (fdone) begin
            pw_q <= fres;
            if (pi_q == 2'd3) begin
              if (dir_q) begin
                cjmv_q <= acc_q; state_q <= S_EVDONE;
              end else begin
                val_q <= acc_q; kind_q <= tcp_pkg::KIND_TC;
                slot_q <= slot_q + 3'd1; state_q <= S_DONE;
              end
            end else begin
              pi_q <= pi_q + 2'd1; state_q <= S_CRD;
            end
          end
        end
        S_EVDONE: begin
          // reporting after the average / cold junction updates
          if (seed_q < 4'd3 && slot_q == 3'd5) begin
            kind_q <= tcp_pkg::KIND_REF; val_q <= reft_q;
            slot_q <= slot_q + 3'd1; state_q <= S_DONE;
          end else if (seed_q < 4'd3 && (slot_q == 3'd0 || slot_q == 3'd4)) begin
            state_q <= S_MVMUL;
          end else begin
            slot_q <= slot_q + 3'd1; state_q <= S_DONE;
          end
        end
        S_DONE:  state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o  = (state_q == S_DONE);
  assign range_o = range_q;
  assign kind_o  = kind_q;
  assign value_o = val_q;
endmodule
`default_nettype wire

// ----- hw/rtl/thermocouple_channel_processor.sv -----
// ----------------------------------------------------------------------------
// thermocouple_channel_processor
// thermocouple rotation with cold-junction compensation on one shared fpu
// ----------------------------------------------------------------------------
//  channel   dir  payload                                        transaction
//  in_if     in   action, sample, table_address, table_word      valid & ready
//  out_if    out  range_select, value_kind, value                valid & ready
//  cfg_if    in   data = ref_mode                                valid & ready
//
//  every float operation runs serially on the two-stage unit
//  a sample result is registered after the average update on slots that only
//  update an average; reporting slots and the reference slot also run a range
//  search over up to five limits plus the four-term cubic
//  load, start and ignored actions pass via the done state to the output register
//  rst_ni clears control and output registers asynchronously, not the coefficient
//  table or fpu data; no transaction is taken while an item is in flight or its
//  result waits in the output register, so a stalled sink holds off the input
// ----------------------------------------------------------------------------
`default_nettype none
`include "thermocouple_channel_processor_defines.svh"
module thermocouple_channel_processor (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tcp_in_if.sink     in_if,
  tcp_out_if.source  out_if,
  tcp_cfg_if.sink    cfg_if
);
  logic [1:0]  ref_mode_q;
  logic        busy_q;       // item in the sequencer
  logic        ovalid_q;
  logic [1:0]  orange_q, okind_q;
  logic [31:0] oval_q;
  logic        go, sdone;
  logic [1:0]  srange, skind;
  logic [31:0] sval;
  logic        oval_ok;

  // a new item waits for an idle sequencer and no older result in the output
  assign in_if.ready  = !busy_q && !ovalid_q;
  assign go           = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  tcp_seq u_seq (
    .clk_i, .rst_ni,
    .go_i(go), .action_i(in_if.action), .sample_i(in_if.sample),
    .addr_i(in_if.table_address), .word_i(in_if.table_word),
    .ref_mode_i(ref_mode_q),
    .done_o(sdone), .range_o(srange), .kind_o(skind), .value_o(sval)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_mode_q <= 2'd0;
      busy_q     <= 1'b0;
      ovalid_q   <= 1'b0;
      orange_q   <= tcp_pkg::RANGE_GND;
      okind_q    <= tcp_pkg::KIND_NONE;
      oval_q     <= '0;
    end else begin
      if (cfg_if.valid) ref_mode_q <= cfg_if.data;
      if (go) busy_q <= 1'b1;
      else if (sdone) busy_q <= 1'b0;
      if (sdone) begin
        ovalid_q <= 1'b1;
        orange_q <= srange;
        okind_q  <= skind;
        oval_q   <= sval;
      end else if (out_if.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_if.valid        = ovalid_q;
  assign out_if.range_select = orange_q;
  assign out_if.value_kind   = okind_q;
  assign out_if.value        = oval_q;

  // a result with no value kind carries a zero value
  assign oval_ok = !ovalid_q || okind_q != tcp_pkg::KIND_NONE || oval_q == 32'd0;

  // no result without an item in flight, and no item taken while one is busy
  `TCP_ASSERT_NEVER(a_done_idle, clk_i, rst_ni, sdone && !busy_q, "result without item")
  `TCP_ASSERT_NEVER(a_go_busy, clk_i, rst_ni, go && busy_q, "item accepted while busy")
  `TCP_ASSERT(a_no_value, clk_i, rst_ni, oval_ok, "value without kind")
endmodule
`default_nettype wire

// ----- tb/tb_thermocouple_channel_processor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thermocouple_channel_processor
// drives samples, table loads and starts through the channel rotation, checks
// every reading against a bit-exact float model of compensation or a literal
// ----------------------------------------------------------------------------
module tb_thermocouple_channel_processor;

  localparam int unsigned IdleLimit  = 3000;
  localparam int unsigned SettleWait = 150;
  localparam int unsigned PhaseItems = 370;
  localparam logic [31:0] F_QNAN     = 32'hffc0_0000;

  typedef struct packed {
    logic [1:0]  rng;
    logic [1:0]  kind;
    logic [31:0] value;
  } reading_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] sample;
    logic [5:0]  addr;
    logic [31:0] word;
    logic        typed;
    reading_t    want;
  } row_t;

  logic clk_i;
  logic rst_ni;

  tcp_in_if  in_ch ();
  tcp_out_if out_ch ();
  tcp_cfg_if cfg_ch ();

  thermocouple_channel_processor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // ------------------------------------------------------------------------
  // software single precision, round to nearest even, subnormals kept
  // ------------------------------------------------------------------------
  function automatic logic is_nan(logic [31:0] a);
    return (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(logic [31:0] a);
    return (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
  endfunction

  function automatic logic [63:0] shr_sticky(logic [63:0] m, int n);
    if (n <= 0) return m;
    if (n >= 64) return {63'd0, |m};
    return (m >> n) | {63'd0, |(m & ((64'd1 << n) - 64'd1))};
  endfunction

  // m holds the significand with its leading one at bit 62, scale 2^(e-127)
  function automatic logic [31:0] round_pack(logic s, int e, logic [63:0] m);
    logic [24:0] mant;
    if (m == 64'd0) return {s, 31'd0};
    while (m[63]) begin
      m = shr_sticky(m, 1);
      e++;
    end
    while (!m[62]) begin
      m = m << 1;
      e--;
    end
    if (e <= 0) begin
      m = shr_sticky(m, 1 - e);
      e = 0;
    end
    mant = {1'b0, m[62:39]};
    if (m[38] && ((|m[37:0]) || m[39])) mant = mant + 25'd1;
    if (mant[24]) begin
      mant = mant >> 1;
      e++;
    end
    if (e == 0 && mant[23]) e = 1;
    if (e >= 255) return {s, 8'hff, 23'd0};
    return {s, e[7:0], mant[22:0]};
  endfunction

  function automatic int eff_exp(logic [31:0] a);
    return (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
  endfunction

  function automatic logic [23:0] signif(logic [31:0] a);
    return {a[30:23] != 8'd0, a[22:0]};
  endfunction

  function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
    logic [63:0] ma, mb, m;
    int e;
    logic s;
    if (is_nan(a)) return a | 32'h0040_0000;
    if (is_nan(b)) return b | 32'h0040_0000;
    if (is_inf(a) && is_inf(b) && a[31] != b[31]) return F_QNAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    ma = {40'd0, signif(a)} << 39;
    mb = {40'd0, signif(b)} << 39;
    if (eff_exp(a) >= eff_exp(b)) begin
      mb = shr_sticky(mb, eff_exp(a) - eff_exp(b));
      e = eff_exp(a);
    end else begin
      ma = shr_sticky(ma, eff_exp(b) - eff_exp(a));
      e = eff_exp(b);
    end
    if (a[31] == b[31]) begin
      m = ma + mb;
      s = a[31];
    end else if (ma > mb) begin
      m = ma - mb;
      s = a[31];
    end else if (mb > ma) begin
      m = mb - ma;
      s = b[31];
    end else begin
      return tcp_pkg::F_ZERO;
    end
    return round_pack(s, e, m);
  endfunction

  function automatic logic [31:0] fsub(logic [31:0] a, logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return fadd(a, b);
    return fadd(a, {~b[31], b[30:0]});
  endfunction

  function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
    logic s;
    logic [63:0] m;
    s = a[31] ^ b[31];
    if (is_nan(a)) return a | 32'h0040_0000;
    if (is_nan(b)) return b | 32'h0040_0000;
    if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0)) return F_QNAN;
    if (is_inf(a) || is_inf(b)) return {s, 8'hff, 23'd0};
    m = (64'(signif(a)) * 64'(signif(b))) << 16;
    return round_pack(s, eff_exp(a) + eff_exp(b) - 127, m);
  endfunction

  function automatic logic flt(logic [31:0] a, logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return 1'b0;
    if (a[31] != b[31]) return a[31];
    if (!a[31]) return a[30:0] < b[30:0];
    return a[30:0] > b[30:0];
  endfunction

  // ------------------------------------------------------------------------
  // channel model: averages, rotation and the cubic table
  // ------------------------------------------------------------------------
  logic [31:0] coef_table [tcp_pkg::TableDepth];
  logic [31:0] tc_avg, gnd_avg, ref_avg, ref_level, cj_mv;
  logic [2:0]  slot;
  logic [3:0]  seed_left;
  logic [1:0]  range_now;
  logic [1:0]  ref_mode;

  // segment search with clamping, then the four-term polynomial
  function automatic logic [31:0] cubic_lookup(int dir, logic [31:0] v);
    int lb, seg;
    logic [31:0] x, acc, pw;
    logic found;
    lb = tcp_pkg::LimitBase + dir * 5;
    seg = 3;
    x = v;
    acc = tcp_pkg::F_ZERO;
    pw = tcp_pkg::F_ONE;
    found = 1'b0;
    if (flt(v, coef_table[lb])) begin
      seg = 0;
      x = coef_table[lb];
    end else begin
      for (int i = 1; i < 5; i++) begin
        if (!found && flt(v, coef_table[lb + i])) begin
          seg = i - 1;
          found = 1'b1;
        end
      end
      if (!found) x = coef_table[lb + 4];
    end
    for (int i = 0; i < 4; i++) begin
      acc = fadd(acc, fmul(pw, coef_table[dir * 16 + seg * 4 + i]));
      pw = fmul(pw, x);
    end
    return acc;
  endfunction

  function automatic logic [31:0] smooth(logic [31:0] avg, logic [31:0] w, logic [31:0] s);
    return fadd(avg, fmul(w, fsub(s, avg)));
  endfunction

  function automatic reading_t compensate_step(row_t it);
    reading_t r;
    logic [31:0] mv;
    r = '{rng: tcp_pkg::RANGE_GND, kind: tcp_pkg::KIND_NONE, value: tcp_pkg::F_ZERO};
    if (it.action == tcp_pkg::ACT_SAMPLE) begin
      range_now = (slot == 3'd0) ? tcp_pkg::RANGE_GND :
                  (slot == 3'd4) ? tcp_pkg::RANGE_TEMP : tcp_pkg::RANGE_MV;
      if (seed_left != 4'd0) begin
        if (slot == 3'd1) gnd_avg = it.sample;
        else if (slot == 3'd2) tc_avg = it.sample;
        else if (slot == 3'd5) ref_avg = it.sample;
        seed_left = seed_left - 4'd1;
      end
      if (slot == 3'd1) begin
        gnd_avg = smooth(gnd_avg, tcp_pkg::F_W_AUX, it.sample);
      end else if (slot == 3'd5) begin
        ref_avg = smooth(ref_avg, tcp_pkg::F_W_AUX, it.sample);
        // reserved mode keeps the previous reference
        if (ref_mode == tcp_pkg::MODE_MEAS) ref_level = ref_avg;
        else if (ref_mode == tcp_pkg::MODE_ZERO) ref_level = tcp_pkg::F_ZERO;
        else if (ref_mode == tcp_pkg::MODE_HALF) ref_level = tcp_pkg::F_HALF;
        cj_mv = cubic_lookup(1, fmul(ref_level, tcp_pkg::F_HUNDRED));
      end else begin
        tc_avg = smooth(tc_avg, tcp_pkg::F_W_TC, it.sample);
      end
      if (seed_left < 4'd3) begin
        if (slot == 3'd5) begin
          r.kind = tcp_pkg::KIND_REF;
          r.value = ref_level;
        end else if (slot == 3'd0 || slot == 3'd4) begin
          mv = fadd(fmul(tc_avg, tcp_pkg::F_MV_SCL), cj_mv);
          r.kind = tcp_pkg::KIND_TC;
          r.value = cubic_lookup(0, mv);
        end
      end
      slot = slot + 3'd1;
    end else if (it.action == tcp_pkg::ACT_LOAD) begin
      if (it.addr < tcp_pkg::TableDepth) coef_table[it.addr] = it.word;
    end else if (it.action == tcp_pkg::ACT_START) begin
      range_now = tcp_pkg::RANGE_GND;
      slot = 3'd0;
      seed_left = tcp_pkg::SeedStart;
    end
    r.rng = range_now;
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // result checking
  // ------------------------------------------------------------------------
  reading_t pending_readings[$];
  int       mismatches;
  int       idle_cycles;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    reading_t w;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected result", out_ch.value, 32'd0);
      end else begin
        w = pending_readings.pop_front();
        if (out_ch.range_select !== w.rng)
          report_mismatch("range_select", 32'(out_ch.range_select), 32'(w.rng));
        if (out_ch.value_kind !== w.kind)
          report_mismatch("value_kind", 32'(out_ch.value_kind), 32'(w.kind));
        if (out_ch.value !== w.value)
          report_mismatch("value", out_ch.value, w.value);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // result sink with random stalls, bursts without stalls
  // ------------------------------------------------------------------------
  initial begin
    int stall;
    logic calm;
    calm = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 49) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  // ------------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------------
  logic [31:0] table_image [tcp_pkg::TableDepth];
  logic        in_calm;

  task automatic send_item(row_t it);
    int gap;
    reading_t r;
    if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.action        <= it.action;
    in_ch.sample        <= it.sample;
    in_ch.table_address <= it.addr;
    in_ch.table_word    <= it.word;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    r = compensate_step(it);
    pending_readings.push_back(it.typed ? it.want : r);
  endtask

  // lets the block go quiet before a register write
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic write_ref_mode(logic [1:0] m);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= m;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    ref_mode = m;
  endtask

  function automatic row_t mk(logic [1:0] act, logic [31:0] smp, logic [5:0] ad,
                              logic [31:0] wd);
    return '{action: act, sample: smp, addr: ad, word: wd, typed: 1'b0, want: '0};
  endfunction

  function automatic row_t lit(row_t it, logic [1:0] rng);
    it.typed = 1'b1;
    it.want = '{rng: rng, kind: tcp_pkg::KIND_NONE, value: tcp_pkg::F_ZERO};
    return it;
  endfunction

  // plausible reading: moderate magnitude, random sign and fraction
  function automatic logic [31:0] plausible();
    return {$urandom_range(0, 4) == 0, 8'($urandom_range(115, 130)), 23'($urandom)};
  endfunction

  function automatic row_t random_item();
    int pick;
    logic [5:0] ad;
    pick = $urandom_range(0, 99);
    if (pick < 3) return mk(tcp_pkg::ACT_START, $urandom, 6'($urandom), $urandom);
    if (pick < 5) begin
      ad = 6'($urandom);
      // sometimes rewrite the sane image, otherwise raw bits
      return mk(tcp_pkg::ACT_LOAD, $urandom, ad,
                ($urandom_range(0, 1) == 0 && ad < tcp_pkg::TableDepth) ?
                table_image[ad] : $urandom);
    end
    if (pick < 6) return mk(tcp_pkg::ACT_RSVD, $urandom, 6'($urandom), $urandom);
    if (pick < 9) return mk(tcp_pkg::ACT_SAMPLE, $urandom, 6'($urandom), $urandom);
    return mk(tcp_pkg::ACT_SAMPLE, plausible(), 6'($urandom), $urandom);
  endfunction

  row_t directed [$];
  logic [1:0] phase_modes [5] = '{tcp_pkg::MODE_HALF, tcp_pkg::MODE_ZERO, tcp_pkg::MODE_RSVD,
                                  tcp_pkg::MODE_MEAS, tcp_pkg::MODE_HALF};

  initial begin
    logic [31:0] lims [10] = '{32'hc100_0000, 32'h0000_0000, 32'h4120_0000, 32'h41f0_0000,
                                32'h4270_0000, 32'hc348_0000, 32'h0000_0000, 32'h437a_0000,
                                32'h4416_0000, 32'h4496_0000};
    logic [31:0] poly [8] = '{32'h0000_0000, 32'h41c8_0000, 32'hbe80_0000, 32'h3a83_126f,
                               32'h0000_0000, 32'h3d23_d70a, 32'h38d1_b717, 32'hb2ab_cc77};
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = tcp_pkg::ACT_SAMPLE;
    in_ch.sample = '0;
    in_ch.table_address = '0;
    in_ch.table_word = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = tcp_pkg::MODE_MEAS;
    in_calm = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    {tc_avg, gnd_avg, ref_avg, ref_level, cj_mv} = '0;
    slot = 3'd0;
    seed_left = 4'd0;
    range_now = tcp_pkg::RANGE_GND;
    ref_mode = tcp_pkg::MODE_MEAS;
    for (int i = 0; i < tcp_pkg::TableDepth; i++) coef_table[i] = tcp_pkg::F_ZERO;

    // coefficient set per direction and segment, limits ascending
    for (int i = 0; i < 32; i++) table_image[i] = poly[(i / 16) * 4 + i % 4] ^ 32'((i / 4) % 4);
    for (int i = 0; i < 10; i++) table_image[tcp_pkg::LimitBase + i] = lims[i];

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the whole table before any sample can read it
    for (int i = 0; i < tcp_pkg::TableDepth; i++)
      send_item(lit(mk(tcp_pkg::ACT_LOAD, 32'd0, 6'(i), table_image[i]), tcp_pkg::RANGE_GND));

    // short walk: ignored actions, start, seeding through a full rotation
    directed.push_back(lit(mk(tcp_pkg::ACT_LOAD, 32'hffff_ffff, 6'd63, 32'hffff_ffff),
                           tcp_pkg::RANGE_GND));
    directed.push_back(lit(mk(tcp_pkg::ACT_RSVD, 32'hffff_ffff, 6'd63, 32'hffff_ffff),
                           tcp_pkg::RANGE_GND));
    directed.push_back(lit(mk(tcp_pkg::ACT_START, 32'd0, 6'd0, 32'd0), tcp_pkg::RANGE_GND));
    directed.push_back(lit(mk(tcp_pkg::ACT_SAMPLE, 32'h0000_0000, 6'd0, 32'd0),
                           tcp_pkg::RANGE_GND));
    directed.push_back(lit(mk(tcp_pkg::ACT_SAMPLE, 32'h0000_0001, 6'd0, 32'd0),
                           tcp_pkg::RANGE_MV));
    directed.push_back(lit(mk(tcp_pkg::ACT_SAMPLE, 32'h7f7f_ffff, 6'd0, 32'd0),
                           tcp_pkg::RANGE_MV));
    directed.push_back(lit(mk(tcp_pkg::ACT_SAMPLE, 32'h3c80_0000, 6'd0, 32'd0),
                           tcp_pkg::RANGE_MV));
    directed.push_back(lit(mk(tcp_pkg::ACT_SAMPLE, 32'h3e80_0000, 6'd0, 32'd0),
                           tcp_pkg::RANGE_TEMP));
    directed.push_back(mk(tcp_pkg::ACT_SAMPLE, 32'h3e80_0000, 6'd0, 32'd0));
    directed.push_back(mk(tcp_pkg::ACT_SAMPLE, 32'h8000_0000, 6'd0, 32'd0));
    directed.push_back(mk(tcp_pkg::ACT_SAMPLE, 32'h3c00_0000, 6'd0, 32'd0));
    directed.push_back(lit(mk(tcp_pkg::ACT_LOAD, 32'd0, 6'd41, table_image[41]),
                           tcp_pkg::RANGE_MV));
    directed.push_back(mk(tcp_pkg::ACT_SAMPLE, 32'h3c00_0000, 6'd0, 32'd0));
    // clamping below the first and above the last limit
    directed.push_back(mk(tcp_pkg::ACT_START, 32'd0, 6'd0, 32'd0));
    for (int i = 0; i < 8; i++)
      directed.push_back(mk(tcp_pkg::ACT_SAMPLE, (i == 2) ? 32'hbf80_0000 : 32'h3e00_0000,
                            6'd0, 32'd0));
    directed.push_back(mk(tcp_pkg::ACT_SAMPLE, 32'h7f80_0000, 6'd0, 32'd0));
    directed.push_back(mk(tcp_pkg::ACT_SAMPLE, 32'hff80_0000, 6'd0, 32'd0));
    directed.push_back(mk(tcp_pkg::ACT_SAMPLE, 32'hffff_ffff, 6'd0, 32'd0));
    foreach (directed[i]) send_item(directed[i]);

    // random phases, each under its own cold-junction source
    foreach (phase_modes[p]) begin
      drain();
      write_ref_mode(phase_modes[p]);
      send_item(mk(tcp_pkg::ACT_START, 32'd0, 6'd0, 32'd0));
      for (int i = 0; i < PhaseItems; i++) send_item(random_item());
    end

    drain();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
